/* hdl/cidx_pkg.sv */
// Shared constants and register codes for the column-major to row-major index generator.
package cidx_pkg;

  localparam int MAX_RANK_DEF   = 6;
  localparam int INDEX_BITS_DEF = 32;

  localparam int DIM_REGS     = 6;
  localparam int DIM_BITS     = 16;
  localparam int RANK_BITS    = 3;
  localparam int EB_BITS      = 5;
  localparam int ACC_BITS     = 36;
  localparam int IN_BITS      = 32;
  localparam int SRC_BITS     = 32;
  localparam int OFS_BITS     = 36;
  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;

  typedef enum logic [2:0] {
    REG_RANK      = 3'd0,
    REG_DIM0      = 3'd1,
    REG_DIM1      = 3'd2,
    REG_DIM2      = 3'd3,
    REG_DIM3      = 3'd4,
    REG_DIM4      = 3'd5,
    REG_DIM5      = 3'd6,
    REG_ELEM_BYTES = 3'd7
  } reg_idx_t;

  typedef logic [DIM_REGS-1:0][DIM_BITS-1:0] dim_arr_t;

endpackage

/* hdl/cidx_regs.sv */
// Configuration register file behind the APB-style port.
module cidx_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cidx_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [cidx_pkg::DATA_BITS-1:0]      pwdata,
  output logic [cidx_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  output logic [cidx_pkg::RANK_BITS-1:0]      rank,
  output cidx_pkg::dim_arr_t                  dim_size,
  output logic [cidx_pkg::EB_BITS-1:0]        element_bytes
);

  logic [cidx_pkg::RANK_BITS-1:0] rank_r;
  cidx_pkg::dim_arr_t             dim_r;
  logic [cidx_pkg::EB_BITS-1:0]   eb_r;
  cidx_pkg::reg_idx_t             sel;
  logic                           wr;

  assign sel    = cidx_pkg::reg_idx_t'(paddr[cidx_pkg::ADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= cidx_pkg::RANK_BITS'(1);
      for (int i = 0; i < cidx_pkg::DIM_REGS; i++) begin
        dim_r[i] <= cidx_pkg::DIM_BITS'(1);
      end
      eb_r <= cidx_pkg::EB_BITS'(1);
    end else if (wr) begin
      unique case (sel)
        cidx_pkg::REG_RANK:       rank_r   <= pwdata[cidx_pkg::RANK_BITS-1:0];
        cidx_pkg::REG_DIM0:       dim_r[0] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_DIM1:       dim_r[1] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_DIM2:       dim_r[2] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_DIM3:       dim_r[3] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_DIM4:       dim_r[4] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_DIM5:       dim_r[5] <= pwdata[cidx_pkg::DIM_BITS-1:0];
        cidx_pkg::REG_ELEM_BYTES: eb_r     <= pwdata[cidx_pkg::EB_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      cidx_pkg::REG_RANK:       prdata = cidx_pkg::DATA_BITS'(rank_r);
      cidx_pkg::REG_DIM0:       prdata = cidx_pkg::DATA_BITS'(dim_r[0]);
      cidx_pkg::REG_DIM1:       prdata = cidx_pkg::DATA_BITS'(dim_r[1]);
      cidx_pkg::REG_DIM2:       prdata = cidx_pkg::DATA_BITS'(dim_r[2]);
      cidx_pkg::REG_DIM3:       prdata = cidx_pkg::DATA_BITS'(dim_r[3]);
      cidx_pkg::REG_DIM4:       prdata = cidx_pkg::DATA_BITS'(dim_r[4]);
      cidx_pkg::REG_DIM5:       prdata = cidx_pkg::DATA_BITS'(dim_r[5]);
      cidx_pkg::REG_ELEM_BYTES: prdata = cidx_pkg::DATA_BITS'(eb_r);
      default:                  prdata = '0;
    endcase
  end

  assign rank          = rank_r;
  assign dim_size      = dim_r;
  assign element_bytes = eb_r;

endmodule

/* hdl/cidx_div_cell.sv */
// One restoring-division step cell: one quotient bit per cycle while en is high, hands on to its neighbour.
module cidx_div_cell #(
  parameter int IB = cidx_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            act,
  input  logic [cidx_pkg::DIM_BITS-1:0]   divisor,
  input  logic                            in_vld,
  input  logic [IB-1:0]                   in_idx,
  input  logic [IB-1:0]                   in_dq,
  input  logic [cidx_pkg::DIM_BITS-1:0]   in_rem,
  input  logic [cidx_pkg::ACC_BITS-1:0]   in_acc,
  output logic                            out_vld,
  output logic [IB-1:0]                   out_idx,
  output logic [IB-1:0]                   out_dq,
  output logic [cidx_pkg::DIM_BITS-1:0]   out_rem,
  output logic [cidx_pkg::ACC_BITS-1:0]   out_acc
);

  logic                           vld_r;
  logic [IB-1:0]                  idx_r, dq_r, dq_nxt;
  logic [cidx_pkg::DIM_BITS-1:0]  rem_r, rem_nxt;
  logic [cidx_pkg::ACC_BITS-1:0]  acc_r;
  logic [cidx_pkg::DIM_BITS:0]    trial, dext;
  logic                           ge;

  always_comb begin
    trial = {in_rem, in_dq[IB-1]};
    dext  = {1'b0, divisor};
    ge    = act && (trial >= dext);
    if (!act) begin
      rem_nxt = in_rem;
      dq_nxt  = in_dq;
    end else begin
      rem_nxt = ge ? cidx_pkg::DIM_BITS'(trial - dext) : trial[cidx_pkg::DIM_BITS-1:0];
      dq_nxt  = {in_dq[IB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= in_idx;
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      acc_r <= in_acc;
    end
  end

  assign out_vld = vld_r;
  assign out_idx = idx_r;
  assign out_dq  = dq_r;
  assign out_rem = rem_r;
  assign out_acc = acc_r;

endmodule

/* hdl/cidx_mac_cell.sv */
// Horner cell: fold one coordinate into the column-major source index.
module cidx_mac_cell #(
  parameter int IB = cidx_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            act,
  input  logic                            first,
  input  logic [cidx_pkg::DIM_BITS-1:0]   dim,
  input  logic                            in_vld,
  input  logic [IB-1:0]                   in_idx,
  input  logic [IB-1:0]                   in_q,
  input  logic [cidx_pkg::DIM_BITS-1:0]   in_coord,
  input  logic [cidx_pkg::ACC_BITS-1:0]   in_acc,
  output logic                            out_vld,
  output logic [IB-1:0]                   out_idx,
  output logic [IB-1:0]                   out_q,
  output logic [cidx_pkg::ACC_BITS-1:0]   out_acc
);

  logic                           vld_r;
  logic [IB-1:0]                  idx_r, q_r;
  logic [cidx_pkg::ACC_BITS-1:0]  acc_r, acc_nxt;

  always_comb begin
    if (!act) begin
      acc_nxt = in_acc;
    end else if (first) begin
      acc_nxt = cidx_pkg::ACC_BITS'(in_coord);
    end else begin
      acc_nxt = cidx_pkg::ACC_BITS'(in_acc * dim) + cidx_pkg::ACC_BITS'(in_coord);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= in_idx;
      q_r   <= in_q;
      acc_r <= acc_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_idx = idx_r;
  assign out_q   = q_r;
  assign out_acc = acc_r;

endmodule

/* hdl/cidx_obuf.sv */
// Two-entry output buffer that parts the pipeline from the result receiver.
module cidx_obuf #(
  parameter int W = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [W-1:0]  out_data
);

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] e0_r, e1_r;
  logic         pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e0_r <= (push && cnt_r == 2'd1) ? push_data : e1_r;
      if (push && cnt_r == 2'd2) begin
        e1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_r <= push_data;
      end else begin
        e1_r <= push_data;
      end
    end
  end

endmodule

/* hdl/col_major_to_row_major_index.sv */
// Top level of the column-major to row-major index generator.
// Usage: program rank, dim_size_0..5 and element_bytes through the APB-style port
// (byte address 4*i for register i) while no item is in flight, then stream
// row-major destination indices in on in_valid/in_stall. Each item yields one
// result on out_valid/out_stall: the column-major source index, both byte
// offsets and an out-of-range flag (other fields zero when it is set).
// Throughput: one item per cycle while in_stall is low. The index is split into coordinates by a row
// of restoring-division cells, one quotient bit per cell, INDEX_BITS cells per
// inner dimension, each followed by a Horner multiply-add cell.
// Results pass the division and Horner cells of each slot, then the final fold and
// byte-offset registers and the two-entry output buffer, on their way to out_valid.
// Reset: rank and every size and element_bytes go to 1; the pipeline and the
// two-entry output buffer empty.
// Stall: results wait in the output buffer; the pipeline freezes and in_stall
// rises only once that buffer is full.
module col_major_to_row_major_index #(
  parameter int MAX_RANK   = cidx_pkg::MAX_RANK_DEF,
  parameter int INDEX_BITS = cidx_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cidx_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [cidx_pkg::DATA_BITS-1:0]      pwdata,
  output logic [cidx_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cidx_pkg::IN_BITS-1:0]        in_dest_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cidx_pkg::SRC_BITS-1:0]       out_src_index,
  output logic [cidx_pkg::OFS_BITS-1:0]       out_src_byte_offset,
  output logic [cidx_pkg::OFS_BITS-1:0]       out_dst_byte_offset,
  output logic                                out_out_of_range
);

  localparam int IB   = INDEX_BITS;
  localparam int LIM  = (MAX_RANK < cidx_pkg::DIM_REGS) ? MAX_RANK : cidx_pkg::DIM_REGS;
  localparam int NS   = LIM - 1;
  localparam int NC   = IB + 1;
  localparam int RB   = cidx_pkg::RANK_BITS;
  localparam int AB   = cidx_pkg::ACC_BITS;
  localparam int DB   = cidx_pkg::DIM_BITS;
  localparam int OW   = cidx_pkg::SRC_BITS + 2*cidx_pkg::OFS_BITS + 1;

  logic [RB-1:0]                rank;
  cidx_pkg::dim_arr_t           dim_size;
  logic [cidx_pkg::EB_BITS-1:0] eb;
  logic [RB-1:0]                ur;
  logic                         en, full;

  cidx_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .rank(rank), .dim_size(dim_size), .element_bytes(eb)
  );

  // Clamp rank to what the hardware can hold.
  assign ur       = (rank > RB'(LIM)) ? RB'(LIM) : rank;
  assign en       = !full;
  assign in_stall = full;

  // Slot boundaries: index 0 is the pipeline entry.
  logic          s_vld [NS+1];
  logic [IB-1:0] s_idx [NS+1];
  logic [IB-1:0] s_q   [NS+1];
  logic [AB-1:0] s_acc [NS+1];

  assign s_vld[0] = in_valid && !full;
  assign s_idx[0] = IB'(in_dest_index);
  assign s_q[0]   = IB'(in_dest_index);
  assign s_acc[0] = '0;

  for (genvar j = 0; j < NS; j++) begin : g_slot
    logic          c_vld [NC];
    logic [IB-1:0] c_idx [NC];
    logic [IB-1:0] c_dq  [NC];
    logic [DB-1:0] c_rem [NC];
    logic [AB-1:0] c_acc [NC];
    logic          act;
    logic [RB-1:0] pos;
    logic [DB-1:0] dsel;

    // Slot j handles dimension ur-1-j, innermost first, while that is above 0.
    assign act  = (ur >= RB'(j + 2));
    assign pos  = act ? RB'(ur - RB'(j + 1)) : RB'(1);
    assign dsel = dim_size[pos];

    assign c_vld[0] = s_vld[j];
    assign c_idx[0] = s_idx[j];
    assign c_dq[0]  = s_q[j];
    assign c_rem[0] = '0;
    assign c_acc[0] = s_acc[j];

    for (genvar k = 0; k < IB; k++) begin : g_cell
      cidx_div_cell #(.IB(IB)) u_div (
        .clk, .rst_n, .en, .act, .divisor(dsel),
        .in_vld(c_vld[k]), .in_idx(c_idx[k]), .in_dq(c_dq[k]),
        .in_rem(c_rem[k]), .in_acc(c_acc[k]),
        .out_vld(c_vld[k+1]), .out_idx(c_idx[k+1]), .out_dq(c_dq[k+1]),
        .out_rem(c_rem[k+1]), .out_acc(c_acc[k+1])
      );
    end

    cidx_mac_cell #(.IB(IB)) u_mac (
      .clk, .rst_n, .en, .act, .first(j == 0), .dim(dsel),
      .in_vld(c_vld[IB]), .in_idx(c_idx[IB]), .in_q(c_dq[IB]),
      .in_coord(c_rem[IB]), .in_acc(c_acc[IB]),
      .out_vld(s_vld[j+1]), .out_idx(s_idx[j+1]), .out_q(s_q[j+1]),
      .out_acc(s_acc[j+1])
    );
  end

  // Final fold with the outermost dimension and the range check.
  logic          fin_vld_r;
  logic [IB-1:0] fin_idx_r;
  logic [AB-1:0] fin_src_r, fin_src_nxt;
  logic          fin_oor_r, fin_oor_nxt;
  logic          zero_dim;
  logic [IB-1:0] lastq, lastidx;
  logic [AB-1:0] lastacc;

  assign lastq   = s_q[NS];
  assign lastidx = s_idx[NS];
  assign lastacc = s_acc[NS];

  always_comb begin
    zero_dim = 1'b0;
    for (int i = 0; i < cidx_pkg::DIM_REGS; i++) begin
      if ((RB'(i) < ur) && (dim_size[i] == '0)) begin
        zero_dim = 1'b1;
      end
    end
    if (ur >= RB'(2)) begin
      fin_oor_nxt = zero_dim || ({{DB{1'b0}}, lastq} >= {{IB{1'b0}}, dim_size[0]});
      fin_src_nxt = AB'(lastacc * dim_size[0]) + AB'(lastq);
    end else if (ur == RB'(1)) begin
      fin_oor_nxt = ({{DB{1'b0}}, lastidx} >= {{IB{1'b0}}, dim_size[0]});
      fin_src_nxt = AB'(lastidx);
    end else begin
      fin_oor_nxt = (lastidx != '0);
      fin_src_nxt = AB'(lastidx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= s_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_idx_r <= lastidx;
      fin_src_r <= fin_src_nxt;
      fin_oor_r <= fin_oor_nxt;
    end
  end

  // Byte offsets; zero the index and both offsets for an index out of range.
  logic                          byt_vld_r;
  logic [cidx_pkg::SRC_BITS-1:0] byt_src_r;
  logic [cidx_pkg::OFS_BITS-1:0] byt_sofs_r, byt_dofs_r;
  logic                          byt_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byt_vld_r <= 1'b0;
    end else if (en) begin
      byt_vld_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byt_oor_r  <= fin_oor_r;
      byt_src_r  <= fin_oor_r ? '0 : cidx_pkg::SRC_BITS'(fin_src_r);
      byt_sofs_r <= fin_oor_r ? '0 : cidx_pkg::OFS_BITS'(fin_src_r * eb);
      byt_dofs_r <= fin_oor_r ? '0 :
                    cidx_pkg::OFS_BITS'(fin_idx_r) * cidx_pkg::OFS_BITS'(eb);
    end
  end

  logic [OW-1:0] ob_data;

  cidx_obuf #(.W(OW)) u_obuf (
    .clk, .rst_n,
    .push(byt_vld_r && en),
    .push_data({byt_src_r, byt_sofs_r, byt_dofs_r, byt_oor_r}),
    .full(full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(ob_data)
  );

  assign {out_src_index, out_src_byte_offset, out_dst_byte_offset, out_out_of_range} = ob_data;

endmodule

/* hdl/cidx_checker.sv */
// Port-level checker for the index generator, bound to the top level.
module cidx_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pready,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cidx_pkg::SRC_BITS-1:0]   out_src_index,
  input  logic [cidx_pkg::OFS_BITS-1:0]   out_src_byte_offset,
  input  logic [cidx_pkg::OFS_BITS-1:0]   out_dst_byte_offset,
  input  logic                            out_out_of_range
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_src_index) && $stable(out_dst_byte_offset))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_src_index == '0 && out_src_byte_offset == '0 && out_dst_byte_offset == '0)
    else $error("out-of-range result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind col_major_to_row_major_index cidx_checker u_cidx_checker (
  .clk, .rst_n, .pready, .out_valid, .out_stall, .out_src_index,
  .out_src_byte_offset, .out_dst_byte_offset, .out_out_of_range
);
